@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ src/ptbank_pkg.sv @@
// ----------------------------------------------------------------------------
// ptbank_pkg
// types and command codes shared by the timer bank cells and top level
// ----------------------------------------------------------------------------
`default_nettype none

package ptbank_pkg;

  localparam int CMD_W  = 3;
  localparam int CHAN_W = 3;
  localparam int LOAD_W = 16;
  localparam int CFG_W  = 4;

  localparam logic [CMD_W-1:0] CMD_TICK         = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START_PERIOD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP_PERIOD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR_FLAG   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_START_TMO    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_STOP_TMO     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_QUERY        = 3'd6;

  localparam logic REG_PERIODS_IN_USE  = 1'b0;
  localparam logic REG_TIMEOUTS_IN_USE = 1'b1;

  localparam logic [CFG_W-1:0] IN_USE_RESET = 4'd8;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAN_W-1:0] channel;
    logic [LOAD_W-1:0] load_value;
  } cmd_t;

  typedef struct packed {
    logic accepted;
    logic period_flag;
    logic timeout_expired;
  } rsp_t;

  // one command traveling down the cell row with its partial result
  typedef struct packed {
    cmd_t item;
    logic p_ok;
    logic t_ok;
    rsp_t res;
  } beat_t;

endpackage

`default_nettype wire

@@ src/ptbank_cell.sv @@
// ----------------------------------------------------------------------------
// ptbank_cell
// one periodic timer and one timeout, applies each passing beat and hands
// it on to the next cell
// ----------------------------------------------------------------------------
`default_nettype none

module ptbank_cell #(
  parameter int  INDEX       = 0,
  parameter bit  HAS_PERIOD  = 1'b1,
  parameter bit  HAS_TIMEOUT = 1'b1,
  parameter int  COUNT_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           advance,
  input  wire logic [ptbank_pkg::CFG_W-1:0]   periods_in_use,
  input  wire logic [ptbank_pkg::CFG_W-1:0]   timeouts_in_use,
  input  wire logic                           beat_in_valid,
  input  wire ptbank_pkg::beat_t              beat_in,
  output logic                                beat_out_valid,
  output ptbank_pkg::beat_t                   beat_out
);
  import ptbank_pkg::*;

  logic                   active, active_next;
  logic                   done, done_next;
  logic [COUNT_WIDTH-1:0] reload, reload_next;
  logic [COUNT_WIDTH-1:0] count, count_next;
  logic [COUNT_WIDTH-1:0] tcount, tcount_next;
  logic [COUNT_WIDTH-1:0] count_dec;
  logic [COUNT_WIDTH-1:0] load;
  logic                   p_live;
  logic                   t_live;
  logic                   hit;
  logic                   p_sel;
  logic                   t_sel;
  beat_t                  beat_next;

  assign p_live    = HAS_PERIOD && (INDEX < int'(periods_in_use));
  assign t_live    = HAS_TIMEOUT && (INDEX < int'(timeouts_in_use));
  assign hit       = (INDEX == int'(beat_in.item.channel));
  assign p_sel     = hit && beat_in.p_ok;
  assign t_sel     = hit && beat_in.t_ok;
  assign load      = COUNT_WIDTH'(beat_in.item.load_value);
  assign count_dec = count - COUNT_WIDTH'(1);

  always_comb begin
    active_next = active;
    done_next   = done;
    reload_next = reload;
    count_next  = count;
    tcount_next = tcount;
    beat_next   = beat_in;
    case (beat_in.item.command)
      CMD_TICK: begin
        if (p_live && active) begin
          if (count_dec == '0) begin
            done_next  = 1'b1;
            count_next = reload;
          end else begin
            count_next = count_dec;
          end
        end
        if (t_live && (tcount != '0)) begin
          tcount_next = tcount - COUNT_WIDTH'(1);
        end
      end
      CMD_START_PERIOD: begin
        if (p_sel) begin
          active_next = 1'b1;
          done_next   = 1'b0;
          reload_next = load;
          count_next  = load;
        end
      end
      CMD_STOP_PERIOD: begin
        if (p_sel) begin
          active_next = 1'b0;
        end
      end
      CMD_CLEAR_FLAG: begin
        if (p_sel) begin
          done_next = 1'b0;
        end
      end
      CMD_START_TMO: begin
        if (t_sel) begin
          tcount_next = load;
        end
      end
      CMD_STOP_TMO: begin
        if (t_sel) begin
          tcount_next = '0;
        end
      end
      default: begin
      end
    endcase
    if (hit) begin
      beat_next.res.period_flag     = beat_in.p_ok && done_next;
      beat_next.res.timeout_expired = beat_in.t_ok && (tcount_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      done           <= 1'b0;
      reload         <= '0;
      count          <= '0;
      tcount         <= '0;
      beat_out_valid <= 1'b0;
    end else if (advance) begin
      beat_out_valid <= beat_in_valid;
      if (beat_in_valid) begin
        active <= active_next;
        done   <= done_next;
        reload <= reload_next;
        count  <= count_next;
        tcount <= tcount_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      beat_out <= beat_next;
    end
  end

endmodule

`default_nettype wire

@@ src/periodic_and_timeout_timer_bank.sv @@
// ----------------------------------------------------------------------------
// periodic_and_timeout_timer_bank
// cell row: max(PERIOD_CHANNELS, TIMEOUT_CHANNELS) cells, one register per cell
// throughput: one command per cycle while the response side takes its beats
// a stalled response holds the whole cell row in place
// reset: all counts, periods and flags zero, both in-use registers at 8
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module periodic_and_timeout_timer_bank #(
  parameter int PERIOD_CHANNELS  = 8,
  parameter int TIMEOUT_CHANNELS = 8,
  parameter int COUNT_WIDTH      = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_addr,
  input  wire logic [ptbank_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire logic                          cmd_valid,
  output logic                               cmd_ready,
  input  wire ptbank_pkg::cmd_t              cmd,
  output logic                               rsp_valid,
  input  wire logic                          rsp_ready,
  output ptbank_pkg::rsp_t                   rsp
);
  import ptbank_pkg::*;

  localparam int CELLS = (PERIOD_CHANNELS > TIMEOUT_CHANNELS) ?
                         PERIOD_CHANNELS : TIMEOUT_CHANNELS;

  logic [CFG_W-1:0] periods_in_use;
  logic [CFG_W-1:0] timeouts_in_use;
  logic             advance;
  logic             p_ok;
  logic             t_ok;
  logic             vld   [CELLS+1];
  beat_t            chain [CELLS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      periods_in_use  <= IN_USE_RESET;
      timeouts_in_use <= IN_USE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PERIODS_IN_USE:  periods_in_use  <= cfg_wdata;
        REG_TIMEOUTS_IN_USE: timeouts_in_use <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign advance   = !vld[CELLS] || rsp_ready;
  assign cmd_ready = advance;

  assign p_ok = (int'(cmd.channel) < int'(periods_in_use)) &&
                (int'(cmd.channel) < PERIOD_CHANNELS);
  assign t_ok = (int'(cmd.channel) < int'(timeouts_in_use)) &&
                (int'(cmd.channel) < TIMEOUT_CHANNELS);

  always_comb begin
    chain[0]      = '0;
    chain[0].item = cmd;
    chain[0].p_ok = p_ok;
    chain[0].t_ok = t_ok;
    case (cmd.command) inside
      CMD_TICK, CMD_QUERY:                               chain[0].res.accepted = 1'b1;
      CMD_START_PERIOD, CMD_STOP_PERIOD, CMD_CLEAR_FLAG: chain[0].res.accepted = p_ok;
      CMD_START_TMO, CMD_STOP_TMO:                       chain[0].res.accepted = t_ok;
      default:                                           chain[0].res.accepted = 1'b0;
    endcase
  end

  assign vld[0] = cmd_valid;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    ptbank_cell #(
      .INDEX       (k),
      .HAS_PERIOD  (k < PERIOD_CHANNELS),
      .HAS_TIMEOUT (k < TIMEOUT_CHANNELS),
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cell (
      .clk             (clk),
      .rst             (rst),
      .advance         (advance),
      .periods_in_use  (periods_in_use),
      .timeouts_in_use (timeouts_in_use),
      .beat_in_valid   (vld[k]),
      .beat_in         (chain[k]),
      .beat_out_valid  (vld[k+1]),
      .beat_out        (chain[k+1])
    );
  end

  assign rsp_valid = vld[CELLS];
  assign rsp       = chain[CELLS].res;

  `ASSERT_NEXT(a_enter_row, clk, rst, cmd_valid && cmd_ready, vld[1])
  `ASSERT_IMPLIES(a_flag_in_range, clk, rst, rsp_valid && rsp.period_flag, chain[CELLS].p_ok)
  `ASSERT_IMPLIES(a_tmo_in_range, clk, rst, rsp_valid && rsp.timeout_expired, chain[CELLS].t_ok)
  `ASSERT_IMPLIES(a_tick_query_ok, clk, rst,
    rsp_valid && (chain[CELLS].item.command == CMD_TICK ||
    chain[CELLS].item.command == CMD_QUERY), rsp.accepted)

endmodule

`default_nettype wire

@@ tb/sv/periodic_and_timeout_timer_bank_checker.sv @@
// ----------------------------------------------------------------------------
// periodic_and_timeout_timer_bank_checker
// watches the config port and both channels of the timer bank, keeps its own
// copy of the periodic timers, timeouts and bank sizes, predicts one response
// per accepted command and compares each response beat field by field
// ----------------------------------------------------------------------------
module periodic_and_timeout_timer_bank_checker (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_addr,
  input  logic [ptbank_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                    cmd_valid,
  input  logic                    cmd_ready,
  input  ptbank_pkg::cmd_t        cmd,
  input  logic                    rsp_valid,
  input  logic                    rsp_ready,
  input  ptbank_pkg::rsp_t        rsp,
  output int                      errors,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import ptbank_pkg::*;

  localparam int NUM_PERIODS  = 8;
  localparam int NUM_TIMEOUTS = 8;

  logic [LOAD_W-1:0] period_len  [NUM_PERIODS];
  logic [LOAD_W-1:0] period_left [NUM_PERIODS];
  logic              period_run  [NUM_PERIODS];
  logic              period_hit  [NUM_PERIODS];
  logic [LOAD_W-1:0] tmo_left    [NUM_TIMEOUTS];
  logic [CFG_W-1:0]  periods_cfg;
  logic [CFG_W-1:0]  timeouts_cfg;
  rsp_t              due_rsp [$];
  int                bad_beats = 0;

  function automatic rsp_t apply_command(input cmd_t c);
    int   np;
    int   nt;
    logic p_ok;
    logic t_ok;
    rsp_t r;
    np = (periods_cfg > NUM_PERIODS) ? NUM_PERIODS : int'(periods_cfg);
    nt = (timeouts_cfg > NUM_TIMEOUTS) ? NUM_TIMEOUTS : int'(timeouts_cfg);
    p_ok = (int'(c.channel) < np);
    t_ok = (int'(c.channel) < nt);
    r.accepted = 1'b0;
    case (c.command)
      CMD_TICK: begin
        for (int i = 0; i < np; i++) begin
          if (period_run[i]) begin
            period_left[i] = period_left[i] - 1'b1;
            if (period_left[i] == '0) begin
              period_hit[i]  = 1'b1;
              period_left[i] = period_len[i];
            end
          end
        end
        for (int i = 0; i < nt; i++) begin
          if (tmo_left[i] != '0) tmo_left[i] = tmo_left[i] - 1'b1;
        end
        r.accepted = 1'b1;
      end
      CMD_START_PERIOD: begin
        if (p_ok) begin
          period_run[c.channel]  = 1'b1;
          period_hit[c.channel]  = 1'b0;
          period_len[c.channel]  = c.load_value;
          period_left[c.channel] = c.load_value;
          r.accepted = 1'b1;
        end
      end
      CMD_STOP_PERIOD: begin
        if (p_ok) begin
          period_run[c.channel] = 1'b0;
          r.accepted = 1'b1;
        end
      end
      CMD_CLEAR_FLAG: begin
        if (p_ok) begin
          period_hit[c.channel] = 1'b0;
          r.accepted = 1'b1;
        end
      end
      CMD_START_TMO: begin
        if (t_ok) begin
          tmo_left[c.channel] = c.load_value;
          r.accepted = 1'b1;
        end
      end
      CMD_STOP_TMO: begin
        if (t_ok) begin
          tmo_left[c.channel] = '0;
          r.accepted = 1'b1;
        end
      end
      CMD_QUERY: r.accepted = 1'b1;
      default: r.accepted = 1'b0;
    endcase
    r.period_flag     = p_ok && period_hit[c.channel];
    r.timeout_expired = t_ok && (tmo_left[c.channel] == '0);
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < NUM_PERIODS; i++) begin
        period_len[i]  = '0;
        period_left[i] = '0;
        period_run[i]  = 1'b0;
        period_hit[i]  = 1'b0;
      end
      for (int i = 0; i < NUM_TIMEOUTS; i++) tmo_left[i] = '0;
      periods_cfg  = IN_USE_RESET;
      timeouts_cfg = IN_USE_RESET;
      due_rsp.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_PERIODS_IN_USE) periods_cfg = cfg_wdata;
        else timeouts_cfg = cfg_wdata;
      end
      if (cmd_valid && cmd_ready) due_rsp.push_back(apply_command(cmd));
      if (rsp_valid && rsp_ready) begin
        if (due_rsp.size() == 0) begin
          bad_beats++;
          $display("%0t: response beat with none outstanding, got acc %0b flag %0b tmo %0b",
                   $time, rsp.accepted, rsp.period_flag, rsp.timeout_expired);
        end else begin
          want = due_rsp.pop_front();
          if (want != rsp) bad_beats++;
          if (want.accepted != rsp.accepted)
            $display("%0t: accepted expected %0b actual %0b",
                     $time, want.accepted, rsp.accepted);
          if (want.period_flag != rsp.period_flag)
            $display("%0t: period_flag expected %0b actual %0b",
                     $time, want.period_flag, rsp.period_flag);
          if (want.timeout_expired != rsp.timeout_expired)
            $display("%0t: timeout_expired expected %0b actual %0b",
                     $time, want.timeout_expired, rsp.timeout_expired);
        end
      end
    end
    errors  <= bad_beats;
    pending <= due_rsp.size();
  end

endmodule

@@ tb/sv/periodic_and_timeout_timer_bank_tb.sv @@
// ----------------------------------------------------------------------------
// periodic_and_timeout_timer_bank_tb
// drives timer bank commands and bank-size writes: a directed sweep of the
// corner cases, then random phases under several bank sizes with random
// gaps and response back-pressure; the checker scores every response beat
// ----------------------------------------------------------------------------
module periodic_and_timeout_timer_bank_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptbank_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int LATENCY         = 8;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int WATCHDOG_LIMIT  = 4000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic             cfg_addr = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             cmd_valid = 1'b0;
  logic             cmd_ready;
  cmd_t             cmd = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  rsp_t             rsp;
  int               errors;
  int               pending;

  bit               idle_en = 1'b1;
  int               hold_off_asked = 0;
  int               hold_off_served = 0;
  int               stall_left = 0;
  int               quiet_cycles = 0;

  logic [CFG_W-1:0] phase_periods  [PHASES] = '{4'd15, 4'd0, 4'd3, 4'd8, 4'd1, 4'd8};
  logic [CFG_W-1:0] phase_timeouts [PHASES] = '{4'd15, 4'd8, 4'd6, 4'd0, 4'd8, 4'd2};

  periodic_and_timeout_timer_bank i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  periodic_and_timeout_timer_bank_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // response side: random stalls plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_ready  <= 1'b0;
    end else if (hold_off_served != hold_off_asked) begin
      hold_off_served <= hold_off_served + 1;
      stall_left      <= HOLD_OFF_CYCLES;
      rsp_ready       <= 1'b0;
    end else begin
      rsp_ready <= !(idle_en && $urandom_range(99) < 9);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("periodic_and_timeout_timer_bank_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic cmd_t make_cmd(input logic [CMD_W-1:0] op, input logic [CHAN_W-1:0] ch,
                                    input logic [LOAD_W-1:0] load);
    cmd_t c;
    c.command    = op;
    c.channel    = ch;
    c.load_value = load;
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int   pick;
    pick = $urandom_range(99);
    if (pick < 35)      c.command = CMD_TICK;
    else if (pick < 50) c.command = CMD_START_PERIOD;
    else if (pick < 57) c.command = CMD_STOP_PERIOD;
    else if (pick < 65) c.command = CMD_CLEAR_FLAG;
    else if (pick < 77) c.command = CMD_START_TMO;
    else if (pick < 82) c.command = CMD_STOP_TMO;
    else if (pick < 95) c.command = CMD_QUERY;
    else                c.command = CMD_UNUSED;
    c.channel = CHAN_W'($urandom_range(7));
    pick = $urandom_range(99);
    if (pick < 70)      c.load_value = LOAD_W'($urandom_range(15));
    else if (pick < 90) c.load_value = LOAD_W'($urandom_range(255));
    else                c.load_value = LOAD_W'($urandom_range(16'hFFFF));
    return c;
  endfunction

  task automatic send_cmd(input cmd_t c);
    while (idle_en && $urandom_range(99) < 9) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic set_bank_sizes(input logic [CFG_W-1:0] periods, input logic [CFG_W-1:0] tmos);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_PERIODS_IN_USE;
    cfg_wdata <= periods;
    @(posedge clk);
    cfg_addr  <= REG_TIMEOUTS_IN_USE;
    cfg_wdata <= tmos;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners with the full bank
    set_bank_sizes(4'd8, 4'd8);
    send_cmd(make_cmd(CMD_QUERY,        3'd0, 16'h0000));
    send_cmd(make_cmd(CMD_START_PERIOD, 3'd0, 16'h0001));
    send_cmd(make_cmd(CMD_START_PERIOD, 3'd7, 16'hFFFF));
    send_cmd(make_cmd(CMD_START_PERIOD, 3'd3, 16'h0000));
    send_cmd(make_cmd(CMD_START_TMO,    3'd0, 16'h0002));
    send_cmd(make_cmd(CMD_START_TMO,    3'd7, 16'hFFFF));
    send_cmd(make_cmd(CMD_TICK,         3'd0, 16'h0000));
    send_cmd(make_cmd(CMD_QUERY,        3'd0, 16'h0000));
    send_cmd(make_cmd(CMD_TICK,         3'd3, 16'hFFFF));
    send_cmd(make_cmd(CMD_CLEAR_FLAG,   3'd0, 16'h0000));
    send_cmd(make_cmd(CMD_STOP_PERIOD,  3'd0, 16'h0000));
    send_cmd(make_cmd(CMD_TICK,         3'd0, 16'h0000));
    send_cmd(make_cmd(CMD_QUERY,        3'd0, 16'h0000));
    send_cmd(make_cmd(CMD_STOP_TMO,     3'd7, 16'h0000));
    send_cmd(make_cmd(CMD_UNUSED,       3'd7, 16'hFFFF));
    send_cmd(make_cmd(CMD_START_TMO,    3'd5, 16'h5555));
    send_cmd(make_cmd(CMD_START_PERIOD, 3'd2, 16'hAAAA));
    send_cmd(make_cmd(CMD_STOP_PERIOD,  3'd3, 16'h0000));
    drain();

    // channels beyond the bank sizes are rejected and left alone by ticks
    set_bank_sizes(4'd2, 4'd3);
    send_cmd(make_cmd(CMD_START_PERIOD, 3'd5, 16'h0001));
    send_cmd(make_cmd(CMD_START_TMO,    3'd2, 16'h0001));
    send_cmd(make_cmd(CMD_START_TMO,    3'd3, 16'h0001));
    send_cmd(make_cmd(CMD_TICK,         3'd7, 16'h0000));
    send_cmd(make_cmd(CMD_QUERY,        3'd2, 16'h0000));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      set_bank_sizes(phase_periods[p], phase_timeouts[p]);
      idle_en = (p != 3);
      if (p == 1 || p == 4) hold_off_asked = hold_off_asked + 1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_cmd(random_cmd());
      drain();
    end

    repeat (4 * LATENCY) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("periodic_and_timeout_timer_bank_tb: done, clean");
    end else begin
      $display("periodic_and_timeout_timer_bank_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/ptbank_pkg.sv
src/ptbank_cell.sv
src/periodic_and_timeout_timer_bank.sv
tb/sv/periodic_and_timeout_timer_bank_checker.sv
tb/sv/periodic_and_timeout_timer_bank_tb.sv
